// ===== hdl/pdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfd_pkg
// Shared types and constants for the PD controller with filtered derivative.
// ----------------------------------------------------------------------------
package pdfd_pkg;

    localparam int REF_W    = 10;
    localparam int GAIN_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 11;
    localparam int ERR_W    = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_TIMES_N    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_RECIP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_MAX       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_MIN       = 3'd7;

    // reset values
    localparam logic [REF_W-1:0]  RST_REFERENCE     = 10'd47;
    localparam logic [GAIN_W-1:0] RST_KP_GAIN       = 16'd523;
    localparam logic [GAIN_W-1:0] RST_KD_TIMES_N    = 16'd2495;
    localparam logic [GAIN_W-1:0] RST_DERIV_RECIP   = 16'd63137;
    localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN   = 16'd13847;
    localparam logic [BYTE_W-1:0] RST_OUTPUT_OFFSET = 8'd140;
    localparam logic [BYTE_W-1:0] RST_CMP_MAX       = 8'd235;
    localparam logic [BYTE_W-1:0] RST_CMP_MIN       = 8'd65;

    typedef struct packed {
        logic [REF_W-1:0]  reference;
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] kd_times_n;
        logic [GAIN_W-1:0] derivative_recip;
        logic [GAIN_W-1:0] output_gain;
        logic [BYTE_W-1:0] output_offset;
        logic [BYTE_W-1:0] cmp_max;
        logic [BYTE_W-1:0] cmp_min;
    } cfg_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_P  = 6'b000010,
        ST_MUL_KD = 6'b000100,
        ST_MUL_R  = 6'b001000,
        ST_MUL_G  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    // shared multiplier operand select
    typedef enum logic [1:0] {
        MUL_SEL_P  = 2'd0,
        MUL_SEL_KD = 2'd1,
        MUL_SEL_R  = 2'd2,
        MUL_SEL_G  = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load_dist;
        mul_sel_t mul_sel;
        logic     load_prop;
        logic     load_sum;
        logic     load_deriv;
        logic     load_gprod;
        logic     load_out;
    } cmd_t;

endpackage

// ===== hdl/pdfd_cfg.sv =====
// ----------------------------------------------------------------------------
// pdfd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pdfd_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pdfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdfd_pkg::CFG_W-1:0]         cfg_data,
    output pdfd_pkg::cfg_t                     cfg
);

    pdfd_pkg::cfg_t cfg_reg;
    pdfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pdfd_pkg::REG_REFERENCE:     cfg_next.reference        = cfg_data[9:0];
                pdfd_pkg::REG_KP_GAIN:       cfg_next.kp_gain          = cfg_data;
                pdfd_pkg::REG_KD_TIMES_N:    cfg_next.kd_times_n       = cfg_data;
                pdfd_pkg::REG_DERIV_RECIP:   cfg_next.derivative_recip = cfg_data;
                pdfd_pkg::REG_OUTPUT_GAIN:   cfg_next.output_gain      = cfg_data;
                pdfd_pkg::REG_OUTPUT_OFFSET: cfg_next.output_offset    = cfg_data[7:0];
                pdfd_pkg::REG_CMP_MAX:       cfg_next.cmp_max          = cfg_data[7:0];
                pdfd_pkg::REG_CMP_MIN:       cfg_next.cmp_min          = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference        <= pdfd_pkg::RST_REFERENCE;
            cfg_reg.kp_gain          <= pdfd_pkg::RST_KP_GAIN;
            cfg_reg.kd_times_n       <= pdfd_pkg::RST_KD_TIMES_N;
            cfg_reg.derivative_recip <= pdfd_pkg::RST_DERIV_RECIP;
            cfg_reg.output_gain      <= pdfd_pkg::RST_OUTPUT_GAIN;
            cfg_reg.output_offset    <= pdfd_pkg::RST_OUTPUT_OFFSET;
            cfg_reg.cmp_max          <= pdfd_pkg::RST_CMP_MAX;
            cfg_reg.cmp_min          <= pdfd_pkg::RST_CMP_MIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/pdfd_datapath.sv =====
// ----------------------------------------------------------------------------
// pdfd_datapath
// Error, shared 34x17 signed multiplier, derivative filter state, output
// scaling, clamp and result register.
// ----------------------------------------------------------------------------
module pdfd_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pdfd_pkg::cfg_t                   cfg,
    input  pdfd_pkg::cmd_t                   cmd,
    input  logic [pdfd_pkg::DIST_W-1:0]      distance_cm,
    output logic [pdfd_pkg::BYTE_W-1:0]      pwm_compare,
    output logic signed [pdfd_pkg::ERR_W-1:0] position_error,
    output logic                             clamped
);

    logic [pdfd_pkg::DIST_W-1:0]       dist_reg;
    logic signed [11:0]                err_reg;
    logic signed [11:0]                err_next;
    logic signed [11:0]                last_err_reg;
    logic signed [28:0]                prop_reg;       // Q16.16
    logic signed [32:0]                sum_reg;        // Q16.16
    logic signed [32:0]                sum_next;
    logic signed [31:0]                deriv_reg;      // Q16.16 filter state
    logic signed [31:0]                deriv_next;
    logic signed [50:0]                gprod_reg;      // Q24.24
    logic signed [12:0]                diff;
    logic signed [32:0]                action;
    logic signed [34:0]                deriv_q;

    logic signed [33:0]                mul_a;
    logic signed [16:0]                mul_b;
    logic signed [50:0]                mul_product;

    logic signed [26:0]                scaled;
    logic signed [27:0]                cmp;
    logic                              hit;

    logic [pdfd_pkg::BYTE_W-1:0]       pwm_reg;
    logic signed [11:0]                err_out_reg;
    logic                              clamped_reg;

    assign err_next = $signed({2'b00, cfg.reference}) - $signed({1'b0, dist_reg});
    assign diff     = {err_reg[11], err_reg} - {last_err_reg[11], last_err_reg};
    assign action   = {{4{prop_reg[28]}}, prop_reg} + {deriv_reg[31], deriv_reg};

    // operand select for the one multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            pdfd_pkg::MUL_SEL_P:
            begin
                mul_a = {{22{err_next[11]}}, err_next};
                mul_b = {1'b0, cfg.kp_gain};
            end
            pdfd_pkg::MUL_SEL_KD:
            begin
                mul_a = {{21{diff[12]}}, diff};
                mul_b = {1'b0, cfg.kd_times_n};
            end
            pdfd_pkg::MUL_SEL_R:
            begin
                mul_a = {sum_reg[32], sum_reg};
                mul_b = {1'b0, cfg.derivative_recip};
            end
            pdfd_pkg::MUL_SEL_G:
            begin
                mul_a = {action[32], action};
                mul_b = {1'b0, cfg.output_gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_product = mul_a * mul_b;

    assign sum_next = {{3{mul_product[29]}}, mul_product[29:0]}
                    + {deriv_reg[31], deriv_reg};

    // floor shift by 16, then saturate to 32 bits
    assign deriv_q = mul_product[50:16];

    always_comb
    begin
        priority if (!deriv_q[34] && (deriv_q[33:31] != 3'b000))
            deriv_next = {1'b0, {31{1'b1}}};
        else if (deriv_q[34] && (deriv_q[33:31] != 3'b111))
            deriv_next = {1'b1, 31'd0};
        else
            deriv_next = deriv_q[31:0];
    end

    // truncate toward zero, add offset, clamp max then min
    always_comb
    begin
        scaled = gprod_reg[50:24];
        if (gprod_reg[50] && (gprod_reg[23:0] != 24'd0))
            scaled = scaled + 27'sd1;
        cmp = {scaled[26], scaled} + $signed({20'd0, cfg.output_offset});
        hit = 1'b0;
        if (cmp > $signed({20'd0, cfg.cmp_max}))
        begin
            cmp = $signed({20'd0, cfg.cmp_max});
            hit = 1'b1;
        end
        if (cmp < $signed({20'd0, cfg.cmp_min}))
        begin
            cmp = $signed({20'd0, cfg.cmp_min});
            hit = 1'b1;
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            deriv_reg    <= '0;
        end
        else if (cmd.load_deriv)
        begin
            last_err_reg <= err_reg;
            deriv_reg    <= deriv_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_dist)
            dist_reg <= distance_cm;
        if (cmd.load_prop)
        begin
            prop_reg <= mul_product[28:0];
            err_reg  <= err_next;
        end
        if (cmd.load_sum)
            sum_reg <= sum_next;
        if (cmd.load_gprod)
            gprod_reg <= mul_product;
        if (cmd.load_out)
        begin
            pwm_reg     <= cmp[7:0];
            err_out_reg <= err_reg;
            clamped_reg <= hit;
        end
    end

    assign pwm_compare    = pwm_reg;
    assign position_error = err_out_reg;
    assign clamped        = clamped_reg;

endmodule

// ===== hdl/pdfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdfd_ctrl
// Sequencer: steps one item through the shared multiplier and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module pdfd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output pdfd_pkg::cmd_t  cmd
);

    pdfd_pkg::state_t state_reg;
    pdfd_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_sel    = pdfd_pkg::MUL_SEL_P;
        unique case (state_reg)
            pdfd_pkg::ST_IDLE:
            begin
                cmd.load_dist = in_valid;
                if (in_valid)
                    state_next = pdfd_pkg::ST_MUL_P;
            end
            pdfd_pkg::ST_MUL_P:
            begin
                cmd.mul_sel   = pdfd_pkg::MUL_SEL_P;
                cmd.load_prop = 1'b1;
                state_next    = pdfd_pkg::ST_MUL_KD;
            end
            pdfd_pkg::ST_MUL_KD:
            begin
                cmd.mul_sel  = pdfd_pkg::MUL_SEL_KD;
                cmd.load_sum = 1'b1;
                state_next   = pdfd_pkg::ST_MUL_R;
            end
            pdfd_pkg::ST_MUL_R:
            begin
                cmd.mul_sel    = pdfd_pkg::MUL_SEL_R;
                cmd.load_deriv = 1'b1;
                state_next     = pdfd_pkg::ST_MUL_G;
            end
            pdfd_pkg::ST_MUL_G:
            begin
                cmd.mul_sel    = pdfd_pkg::MUL_SEL_G;
                cmd.load_gprod = 1'b1;
                state_next     = pdfd_pkg::ST_OUT;
            end
            pdfd_pkg::ST_OUT:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    state_next = pdfd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pdfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != pdfd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == pdfd_pkg::ST_MUL_P))
        else $error("accepted item did not start the multiply sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while a result is still held");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pdfd_pkg::ST_OUT))
        else $error("result shown without passing the output step");

    a_filter_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_deriv |=> !cmd.load_deriv && (state_reg == pdfd_pkg::ST_MUL_G))
        else $error("filter state updated out of sequence");
`endif

endmodule

// ===== hdl/pd_filtered_derivative_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// pd_filtered_derivative_pwm_unit
// PD position controller with filtered derivative driving a PWM compare value.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, distance_cm           | item in
//  out     | out_valid, out_stall, pwm_compare,        | item out
//          | position_error, clamped                   |
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
//  Each item passes through the accept step, four passes through the single
//  shared 34x17 signed multiplier (P, Kd*N*diff, filter reciprocal, output
//  gain) and an output step for truncation, offset and clamp.
//  in_stall is high from the accept until the result is moved into the
//  output register; the output register holds a result under out_stall while
//  the next item is accepted, and only the final step waits on it.
//  Reset (rst_n, async, low) loads the register reset values, clears the
//  last error and filter state and empties the output register.
//
//  Math: error = reference - distance; P = kp*error (Q16.16);
//  D = floor(((kdn*(error-last_error)) + D) * recip / 2^16), saturated to
//  32 bits; compare = trunc((P+D)*gain / 2^24) + offset, clamped to max and
//  then min, with clamped set whenever either limit acted.
// ----------------------------------------------------------------------------
module pd_filtered_derivative_pwm_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [pdfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdfd_pkg::CFG_W-1:0]         cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pdfd_pkg::DIST_W-1:0]        distance_cm,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pdfd_pkg::BYTE_W-1:0]        pwm_compare,
    output logic signed [pdfd_pkg::ERR_W-1:0]  position_error,
    output logic                               clamped
);

    pdfd_pkg::cfg_t cfg;
    pdfd_pkg::cmd_t cmd;

    // register file
    pdfd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer and handshakes
    pdfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // arithmetic, filter state and result register
    pdfd_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .distance_cm    (distance_cm),
        .pwm_compare    (pwm_compare),
        .position_error (position_error),
        .clamped        (clamped)
    );

endmodule
